FILE: rtl/core/rth_pkg.sv
package rth_pkg;

  localparam int IN_BITS_DEF  = 8;
  localparam int OUT_BITS_DEF = 16;

  // division lanes carried through the cell chain
  localparam int LANES    = 3;
  localparam int LANE_HUE = 0;
  localparam int LANE_SAT = 1;
  localparam int LANE_LIG = 2;

  typedef struct packed {
    logic valid;
    logic gray;
  } rth_ctl_t;

endpackage

FILE: rtl/core/rth_if.sv
interface rth_rgb_if #(
  parameter int W = rth_pkg::IN_BITS_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] red;
  logic [W-1:0] green;
  logic [W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsl_if #(
  parameter int W = rth_pkg::OUT_BITS_DEF
);
  logic         valid;
  logic         ready;
  logic [W-1:0] hue;
  logic [W-1:0] saturation;
  logic [W-1:0] lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

FILE: rtl/core/rth_front.sv
module rth_front #(
  parameter int IN_BITS = rth_pkg::IN_BITS_DEF,
  parameter int RW      = IN_BITS + 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   valid,
  input  logic [IN_BITS-1:0]     red,
  input  logic [IN_BITS-1:0]     green,
  input  logic [IN_BITS-1:0]     blue,
  output rth_pkg::rth_ctl_t      ctl,
  output logic [2:0][RW-1:0]     rem,
  output logic [2:0][RW-1:0]     div
);
  import rth_pkg::*;

  localparam logic [RW-1:0] MAXC = RW'((1 << IN_BITS) - 1);

  logic [RW-1:0] r, g, b, mx, mn, d, sum, pos, sden;
  logic [2:0][RW-1:0] rem_next, div_next;

  always_comb begin
    r = RW'(red);
    g = RW'(green);
    b = RW'(blue);
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d   = mx - mn;
    sum = mx + mn;
    if (mx == r) begin
      pos = (g >= b) ? (g - b) : (RW'(6) * d - (b - g));
    end else if (mx == g) begin
      pos = b + (d << 1) - r;
    end else begin
      pos = r + (d << 2) - g;
    end
    sden = (sum <= MAXC) ? sum : ((MAXC << 1) - sum);
    // divisors are doubled so every cell can shift first
    rem_next[LANE_HUE] = pos;
    div_next[LANE_HUE] = RW'(12) * d;
    rem_next[LANE_SAT] = d;
    div_next[LANE_SAT] = sden << 1;
    rem_next[LANE_LIG] = sum;
    div_next[LANE_LIG] = MAXC << 2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (en) begin
      ctl.valid <= valid;
    end
    if (en) begin
      ctl.gray <= (d == '0);
      rem      <= rem_next;
      div      <= div_next;
    end
  end

endmodule

FILE: rtl/core/rth_cell.sv
module rth_cell #(
  parameter int RW = rth_pkg::IN_BITS_DEF + 4,
  parameter int QW = rth_pkg::OUT_BITS_DEF + 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  rth_pkg::rth_ctl_t      ctl_in,
  input  logic [2:0][RW-1:0]     rem_in,
  input  logic [2:0][RW-1:0]     div_in,
  input  logic [2:0][QW-1:0]     quo_in,
  output rth_pkg::rth_ctl_t      ctl_out,
  output logic [2:0][RW-1:0]     rem_out,
  output logic [2:0][RW-1:0]     div_out,
  output logic [2:0][QW-1:0]     quo_out
);
  import rth_pkg::*;

  logic [2:0][RW:0]   trial;
  logic [2:0]         qbit;
  logic [2:0][RW-1:0] rem_next;

  // one restoring division step per lane
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      trial[i] = {rem_in[i], 1'b0};
      qbit[i]  = (trial[i] >= {1'b0, div_in[i]});
      rem_next[i] = qbit[i] ? RW'(trial[i] - {1'b0, div_in[i]}) : RW'(trial[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.gray <= ctl_in.gray;
      rem_out      <= rem_next;
      div_out      <= div_in;
      for (int i = 0; i < LANES; i++) begin
        quo_out[i] <= {quo_in[i][QW-2:0], qbit[i]};
      end
    end
  end

endmodule

FILE: rtl/core/rgb_to_hsl_converter.sv
// RGB to HSL converter.
// pix (sink) takes one pixel per transaction: red, green, blue, each an
// IN_BITS code for 0.0 to 1.0. hsl (source) gives hue, saturation and
// lightness as unsigned Q0.OUT_BITS fractions, rounded to nearest.
// Throughput: one pixel per clock while hsl is not stalled.
// Stages: one front cell that finds max, min and the numerators,
// OUT_BITS + 2 division cells that each produce one quotient bit for all
// three results, and the output register.
// The chain advances as a whole; when hsl holds valid without ready, every
// stage holds and pix.ready drops, so nothing is lost. Reset clears all
// valid flags; results already in flight are dropped.
module rgb_to_hsl_converter #(
  parameter int IN_BITS  = rth_pkg::IN_BITS_DEF,
  parameter int OUT_BITS = rth_pkg::OUT_BITS_DEF
) (
  input logic clk,
  input logic rst,
  rth_rgb_if.sink   pix,
  rth_hsl_if.source hsl
);
  import rth_pkg::*;

  localparam int RW = IN_BITS + 4;
  localparam int QW = OUT_BITS + 2;
  localparam int NC = OUT_BITS + 2;

  logic en;
  rth_ctl_t           ctl [0:NC];
  logic [2:0][RW-1:0] rem [0:NC];
  logic [2:0][RW-1:0] div [0:NC];
  logic [2:0][QW-1:0] quo [0:NC];
  logic [2:0][QW-1:0] rnd;
  logic [OUT_BITS-1:0] hue_next, sat_next, lig_next;

  assign en        = !hsl.valid || hsl.ready;
  assign pix.ready = en;
  assign quo[0]    = '0;

  rth_front #(.IN_BITS(IN_BITS), .RW(RW)) u_front (
    .clk(clk), .rst(rst), .en(en), .valid(pix.valid),
    .red(pix.red), .green(pix.green), .blue(pix.blue),
    .ctl(ctl[0]), .rem(rem[0]), .div(div[0])
  );

  for (genvar k = 0; k < NC; k++) begin : g_cell
    rth_cell #(.RW(RW), .QW(QW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .ctl_in(ctl[k]), .rem_in(rem[k]), .div_in(div[k]), .quo_in(quo[k]),
      .ctl_out(ctl[k+1]), .rem_out(rem[k+1]), .div_out(div[k+1]),
      .quo_out(quo[k+1])
    );
  end

  // quotient carries one extra fraction bit: add half and drop it
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rnd[i] = quo[NC][i] + QW'(1);
    end
    hue_next = rnd[LANE_HUE][OUT_BITS:1];
    sat_next = rnd[LANE_SAT][OUT_BITS+1] ? '1 : rnd[LANE_SAT][OUT_BITS:1];
    lig_next = rnd[LANE_LIG][OUT_BITS+1] ? '1 : rnd[LANE_LIG][OUT_BITS:1];
    if (ctl[NC].gray) begin
      hue_next = '0;
      sat_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hsl.valid <= 1'b0;
    end else if (en) begin
      hsl.valid <= ctl[NC].valid;
    end
    if (en) begin
      hsl.hue        <= hue_next;
      hsl.saturation <= sat_next;
      hsl.lightness  <= lig_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    ctl[NC].valid && !ctl[NC].gray |->
      (rem[NC][LANE_HUE] < div[NC][LANE_HUE]) &&
      (rem[NC][LANE_SAT] < div[NC][LANE_SAT]))
    else $error("division remainder not below divisor");

  a_lig_bound: assert property (@(posedge clk) disable iff (rst)
    ctl[NC].valid |-> rem[NC][LANE_LIG] < div[NC][LANE_LIG])
    else $error("lightness remainder not below divisor");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    en && ctl[0].valid |=> ctl[1].valid)
    else $error("transaction lost between front and first cell");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(ctl[NC].valid) && $stable(quo[NC]))
    else $error("chain moved while output stalled");
`endif

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rth_pkg::*;

  localparam int IW = IN_BITS_DEF;
  localparam int OW = OUT_BITS_DEF;
  localparam int LATENCY = OW + 4;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PIXELS = 1800;
  localparam int N_DIRECTED = 20;

  typedef struct packed {
    logic [OW-1:0] hue;
    logic [OW-1:0] sat;
    logic [OW-1:0] lig;
  } hsl_t;

  typedef struct {
    logic [IW-1:0] r, g, b;
    bit            typed;
    hsl_t          res;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rth_rgb_if #(.W(IW)) pix ();
  rth_hsl_if #(.W(OW)) hsl ();

  rgb_to_hsl_converter #(.IN_BITS(IW), .OUT_BITS(OW)) dut (
    .clk(clk),
    .rst(rst),
    .pix(pix.sink),
    .hsl(hsl.source)
  );

  always #5 clk = ~clk;

  hsl_t   hsl_expected[$];
  int     errors = 0;
  int     idle_cycles = 0;
  bit     stim_done = 1'b0;
  bit     long_hold = 1'b0;

  // exact rational value rounded to nearest, ties upward
  function automatic longint unsigned round_frac(longint unsigned num, longint unsigned den);
    return ((num << OW) + den / 2) / den;
  endfunction

  function automatic hsl_t predict_hsl(logic [IW-1:0] r, logic [IW-1:0] g, logic [IW-1:0] b);
    longint unsigned full, mx, mn, d, sum, pos, v;
    hsl_t o;
    full = (64'd1 << IW) - 1;
    mx = 64'(r); if (g > mx) mx = 64'(g); if (b > mx) mx = 64'(b);
    mn = 64'(r); if (g < mn) mn = 64'(g); if (b < mn) mn = 64'(b);
    d = mx - mn;
    sum = mx + mn;
    v = round_frac(sum, 2 * full);
    o.lig = (v >> OW) != 0 ? '1 : v[OW-1:0];
    if (d == 0) begin
      o.hue = '0;
      o.sat = '0;
    end else begin
      if (mx == r) pos = (g >= b) ? 64'(g) - 64'(b) : 6 * d - (64'(b) - 64'(g));
      else if (mx == g) pos = 64'(b) + 2 * d - 64'(r);
      else pos = 64'(r) + 4 * d - 64'(g);
      v = round_frac(pos, 6 * d);
      o.hue = v[OW-1:0];  // full turn wraps to zero
      v = (sum <= full) ? round_frac(d, sum) : round_frac(d, 2 * full - sum);
      o.sat = (v >> OW) != 0 ? '1 : v[OW-1:0];
    end
    return o;
  endfunction

  // directed pixels; results typed in only where obvious
  pixel_row_t pixel_table[N_DIRECTED];
  initial begin
    pixel_table[0]  = '{8'd0,   8'd0,   8'd0,   1, '{16'd0, 16'd0, 16'd0}};
    pixel_table[1]  = '{8'd255, 8'd255, 8'd255, 1, '{16'd0, 16'd0, 16'hFFFF}};
    pixel_table[2]  = '{8'd255, 8'd0,   8'd0,   1, '{16'd0, 16'hFFFF, 16'h8000}};
    pixel_table[3]  = '{8'd128, 8'd128, 8'd128, 0, '0};
    pixel_table[4]  = '{8'd0,   8'd255, 8'd0,   0, '0};
    pixel_table[5]  = '{8'd0,   8'd0,   8'd255, 0, '0};
    pixel_table[6]  = '{8'd255, 8'd255, 8'd0,   0, '0};  // red wins tie with green
    pixel_table[7]  = '{8'd0,   8'd255, 8'd255, 0, '0};  // green wins tie with blue
    pixel_table[8]  = '{8'd255, 8'd0,   8'd255, 0, '0};
    pixel_table[9]  = '{8'd255, 8'd0,   8'd1,   0, '0};  // negative red offset, near full turn
    pixel_table[10] = '{8'd255, 8'd1,   8'd0,   0, '0};
    pixel_table[11] = '{8'd1,   8'd0,   8'd0,   0, '0};
    pixel_table[12] = '{8'd255, 8'd254, 8'd254, 0, '0};
    pixel_table[13] = '{8'd127, 8'd0,   8'd0,   0, '0};
    pixel_table[14] = '{8'd128, 8'd0,   8'd0,   0, '0};
    pixel_table[15] = '{8'd255, 8'd128, 8'd0,   0, '0};
    pixel_table[16] = '{8'd170, 8'd85,  8'd0,   0, '0};
    pixel_table[17] = '{8'd0,   8'd1,   8'd255, 0, '0};
    pixel_table[18] = '{8'd85,  8'd170, 8'd255, 0, '0};
    pixel_table[19] = '{8'd1,   8'd1,   8'd1,   0, '0};
  end

  task automatic send_pixel(logic [IW-1:0] r, logic [IW-1:0] g, logic [IW-1:0] b,
                            bit typed, hsl_t res);
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    do @(posedge clk); while (!pix.ready);
    hsl_expected.push_back(typed ? res : predict_hsl(r, g, b));
  endtask

  task automatic pause_sender();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    int burst;
    pix.valid <= 1'b0;
    pix.red   <= '0;
    pix.green <= '0;
    pix.blue  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (pixel_table[i])
      send_pixel(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b,
                 pixel_table[i].typed, pixel_table[i].res);
    burst = 0;
    for (int n = 0; n < RANDOM_PIXELS; n++) begin
      logic [IW-1:0] r, g, b;
      r = IW'($urandom); g = IW'($urandom); b = IW'($urandom);
      case ($urandom_range(0, 7))
        0: g = r;                    // red and green tie
        1: begin g = r; b = r; end   // gray
        2: b = g;
        default: ;
      endcase
      if (n == 600) long_hold = 1'b1;
      send_pixel(r, g, b, 1'b0, '0);
      if (burst == 0) begin
        pause_sender();
        burst = $urandom_range(1, 40);
      end else begin
        burst--;
      end
    end
    pix.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: stall pattern of its own, plus one long hold-off
  initial begin
    int phase;
    hsl.ready <= 1'b0;
    phase = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        hsl.ready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      phase = (phase + 1) % 64;
      if (phase < 20) hsl.ready <= 1'b1;
      else if (phase < 40) hsl.ready <= ($urandom_range(0, 2) != 0);
      else hsl.ready <= 1'($urandom_range(0, 1));
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && hsl.valid && hsl.ready) begin
      if (hsl_expected.size() == 0) begin
        $display("%0t: unexpected result hue=%h sat=%h lig=%h", $time,
                 hsl.hue, hsl.saturation, hsl.lightness);
        errors++;
      end else begin
        hsl_t e;
        e = hsl_expected.pop_front();
        if (hsl.hue !== e.hue) begin
          $display("%0t: hue expected %h actual %h", $time, e.hue, hsl.hue);
          errors++;
        end
        if (hsl.saturation !== e.sat) begin
          $display("%0t: saturation expected %h actual %h", $time, e.sat, hsl.saturation);
          errors++;
        end
        if (hsl.lightness !== e.lig) begin
          $display("%0t: lightness expected %h actual %h", $time, e.lig, hsl.lightness);
          errors++;
        end
      end
    end
  end

  // watchdog: count cycles with no transaction on either side
  always @(posedge clk) begin
    if ((pix.valid && pix.ready) || (hsl.valid && hsl.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (hsl_expected.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0 && hsl_expected.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/rth_pkg.sv
rtl/core/rth_if.sv
rtl/core/rth_front.sv
rtl/core/rth_cell.sv
rtl/core/rgb_to_hsl_converter.sv
bench/tb_top.sv
